### rtl/core/multichannel_moving_median_top_assert.svh
// assertion macros for the multichannel moving median block
// used by the port checker; needs signals named clock and reset in scope
`ifndef MULTICHANNEL_MOVING_MEDIAN_TOP_ASSERT_SVH
`define MULTICHANNEL_MOVING_MEDIAN_TOP_ASSERT_SVH

// property checked outside reset
`define MMED_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also covers the reset cycles
`define MMED_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/mmed_pkg.sv
// shared types and constants of the multichannel moving median block
// no dependencies
`default_nettype none

package mmed_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CHAN_W   = 5;
   localparam int WIN_W    = 4;
   localparam int STATUS_W = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [CHAN_W-1:0]          chan_type;
   typedef logic [WIN_W-1:0]           win_type;
   typedef logic [STATUS_W-1:0]        status_type;

   // result status codes
   localparam status_type STATUS_MEDIAN = 2'd0;
   localparam status_type STATUS_BYPASS = 2'd1;
   localparam status_type STATUS_REJECT = 2'd2;

endpackage

`default_nettype wire

### rtl/core/mmed_if.sv
// valid/ready channel interfaces for request and response items
// depends on mmed_pkg
`default_nettype none

interface mmed_req_if;
   logic                valid;
   logic                ready;
   mmed_pkg::chan_type   channel;
   mmed_pkg::win_type    window_len;
   mmed_pkg::sample_type sample;

   modport source (output valid, output channel, output window_len, output sample,
                   input ready);
   modport sink   (input valid, input channel, input window_len, input sample,
                   output ready);
endinterface

interface mmed_rsp_if;
   logic                valid;
   logic                ready;
   mmed_pkg::sample_type median;
   mmed_pkg::status_type status;

   modport source (output valid, output median, output status, input ready);
   modport sink   (input valid, input median, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/multichannel_moving_median_top.sv
// multichannel moving median: sample store and slot counters in memories
// depends on mmed_pkg and mmed_if
//
//   channel   dir   payload                          handshake
//   req_ch    in    channel, window_len, sample      valid / ready
//   rsp_ch    out   median, status                   valid / ready
//
// median item: reads one window slot per cycle from the sample memory and ranks
//   it on arrival
// bypass or reject item: goes from idle straight to done, no memory write
// after reset a clearing pass zeroes both memories (CHANNELS * 2**SW sample
//   entries, 480 at the defaults); req ready stays low until it ends
// a stalled response holds in the output register; the next item waits in done
`default_nettype none

module multichannel_moving_median_top #(
   parameter int CHANNELS     = 30,
   parameter int WINDOW_SLOTS = 11
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mmed_req_if.sink    req_ch,
   mmed_rsp_if.source  rsp_ch
);

   // largest usable window, limited by the window field
   localparam int MAX_WIN = (WINDOW_SLOTS - 1 < 15) ? WINDOW_SLOTS - 1 : 15;
   localparam int SW      = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
   localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW      = CW + SW;
   localparam int DEPTH   = CHANNELS << SW;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [8:0]    CH_LIMIT  = 9'(CHANNELS);
   localparam logic [5:0]    WIN_LIMIT = 6'(WINDOW_SLOTS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_SELECT = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // memories
   mmed_pkg::sample_type smp_mem [0:DEPTH-1];
   mmed_pkg::win_type    cnt_mem [0:CHANNELS-1];

   // control state
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   logic [CW-1:0]          ch_ff;
   mmed_pkg::win_type      win_ff;
   mmed_pkg::sample_type   smp_ff;
   mmed_pkg::win_type      cnt_rd_ff;
   mmed_pkg::sample_type   smp_rd_ff;
   mmed_pkg::win_type      rd_idx_ff, rd_idx_in;
   mmed_pkg::win_type      rd_pos_ff;
   mmed_pkg::sample_type   buf_ff  [0:MAX_WIN-1];
   mmed_pkg::win_type      rank_ff [0:MAX_WIN-1];
   mmed_pkg::sample_type   res_med_ff, res_med_in;
   mmed_pkg::status_type   res_sts_ff, res_sts_in;
   mmed_pkg::sample_type   rsp_med_ff;
   mmed_pkg::status_type   rsp_sts_ff;

   // combinational helpers
   logic                 req_acc;
   logic                 rsp_load;
   logic [CW+4:0]        req_ch_ext;
   logic [CW-1:0]        req_ch_idx;
   logic [4:0]           slot_inc;
   mmed_pkg::win_type    slot_new;
   logic                 smp_we;
   logic [AW-1:0]        smp_waddr;
   mmed_pkg::sample_type smp_wdata;
   logic [AW-1:0]        smp_raddr;
   logic                 cnt_we;
   logic [CW-1:0]        cnt_waddr;
   mmed_pkg::win_type    cnt_wdata;
   logic                 elem_last;
   mmed_pkg::win_type    elem_rank;
   mmed_pkg::win_type    target;
   mmed_pkg::sample_type sel_med;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.median = rsp_med_ff;
   assign rsp_ch.status = rsp_sts_ff;
   assign rsp_load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // channel field narrowed to the memory row index
   assign req_ch_ext = {{CW{1'b0}}, req_ch.channel};
   assign req_ch_idx = req_ch_ext[CW-1:0];

   // pre-incremented slot, wrapping at the window length
   assign slot_inc = {1'b0, cnt_rd_ff} + 5'd1;
   assign slot_new = (slot_inc >= {1'b0, win_ff}) ? '0 : slot_inc[3:0];

   // rank of the arriving element among those already read
   always_comb begin
      elem_rank = '0;
      for (int k = 0; k < MAX_WIN; k++) begin
         if ((4'(k) < rd_pos_ff) && (buf_ff[k] <= smp_rd_ff)) begin
            elem_rank = elem_rank + 4'd1;
         end
      end
   end

   assign elem_last = rd_vld_ff && (rd_pos_ff == win_ff - 4'd1);

   // pick the element whose rank is window_len/2
   assign target = win_ff >> 1;
   always_comb begin
      sel_med = '0;
      for (int k = 0; k < MAX_WIN; k++) begin
         if ((4'(k) < win_ff) && (rank_ff[k] == target)) begin
            sel_med = buf_ff[k];
         end
      end
   end

   // memory write and read ports
   always_comb begin
      smp_we    = 1'b0;
      smp_waddr = clr_addr_ff;
      smp_wdata = '0;
      cnt_we    = 1'b0;
      cnt_waddr = clr_addr_ff[AW-1:SW];
      cnt_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            smp_we = 1'b1;
            cnt_we = 1'b1;
         end
         ST_UPDATE: begin
            smp_we    = 1'b1;
            smp_waddr = {ch_ff, slot_new[SW-1:0]};
            smp_wdata = smp_ff;
            cnt_we    = 1'b1;
            cnt_waddr = ch_ff;
            cnt_wdata = slot_new;
         end
         default: begin
         end
      endcase
   end

   assign smp_raddr = {ch_ff, rd_idx_ff[SW-1:0]};

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_waddr] <= smp_wdata;
      end
      smp_rd_ff <= smp_mem[smp_raddr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[req_ch_idx];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      res_med_in   = res_med_ff;
      res_sts_in   = res_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.window_len == '0) begin
                  res_med_in = req_ch.sample;
                  res_sts_in = mmed_pkg::STATUS_BYPASS;
                  state_in   = ST_DONE;
               end else if (({4'b0, req_ch.channel} >= CH_LIMIT) ||
                            ({2'b0, req_ch.window_len} >= WIN_LIMIT)) begin
                  res_med_in = '0;
                  res_sts_in = mmed_pkg::STATUS_REJECT;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            rd_idx_in = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            if (rd_idx_ff != win_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff + 4'd1;
            end
            if (elem_last) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            res_med_in = sel_med;
            res_sts_in = mmed_pkg::STATUS_MEDIAN;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture, read position and result staging
   always_ff @(posedge clock) begin
      if (req_acc) begin
         ch_ff  <= req_ch_idx;
         win_ff <= req_ch.window_len;
         smp_ff <= req_ch.sample;
      end
      rd_idx_ff  <= rd_idx_in;
      rd_pos_ff  <= rd_idx_ff;
      res_med_ff <= res_med_in;
      res_sts_ff <= res_sts_in;
      if (rsp_load) begin
         rsp_med_ff <= res_med_ff;
         rsp_sts_ff <= res_sts_ff;
      end
   end

   // ranking lanes: store the arriving element, bump ranks of larger ones
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         for (int k = 0; k < MAX_WIN; k++) begin
            if (4'(k) == rd_pos_ff) begin
               buf_ff[k]  <= smp_rd_ff;
               rank_ff[k] <= elem_rank;
            end else if ((4'(k) < rd_pos_ff) && (smp_rd_ff < buf_ff[k])) begin
               rank_ff[k] <= rank_ff[k] + 4'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/mmed_checker.sv
// port-level checker for the multichannel moving median top level, with its bind
// depends on mmed_pkg and multichannel_moving_median_top_assert.svh
`default_nettype none

`include "multichannel_moving_median_top_assert.svh"

module mmed_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire mmed_pkg::sample_type rsp_median,
   input wire mmed_pkg::status_type rsp_status
);

   // reset empties the output register
   `MMED_ASSERT_RST(a_rst_rsp_idle, reset |=> !rsp_valid, "response valid after reset")

   // reset starts the clearing pass, so no item is taken
   `MMED_ASSERT_RST(a_rst_req_block, reset |=> !req_ready, "request ready after reset")

   // one item at a time: ready drops right after an accept
   `MMED_ASSERT(a_one_item, req_valid && req_ready |=> !req_ready, "second item taken")

   // a stalled response holds
   `MMED_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median) && $stable(rsp_status), "stalled response changed")

   // status is one of the three codes
   `MMED_ASSERT(a_status_code, rsp_valid |-> rsp_status == mmed_pkg::STATUS_MEDIAN || rsp_status == mmed_pkg::STATUS_BYPASS || rsp_status == mmed_pkg::STATUS_REJECT, "bad status code")

endmodule

bind multichannel_moving_median_top mmed_checker u_mmed_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_median (rsp_ch.median),
   .rsp_status (rsp_ch.status)
);

`default_nettype wire
